@@ rtl/mgrad_pkg.sv @@
package mgrad_pkg;

    localparam int PIX_W    = 8;
    localparam int WIN      = 3;
    localparam int LINES    = WIN - 1;
    localparam int WIN_AREA = WIN * WIN;
    localparam int CFG_W    = 11;
    localparam int COORD_W  = 10;

    localparam logic [CFG_W-1:0]   WIDTH_RESET = 11'd1024;
    localparam logic [COORD_W-1:0] ROW_LIMIT   = 10'd1023;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef pix_t [WIN_AREA-1:0] win_t;
    typedef logic [COORD_W-1:0] coord_t;

endpackage

@@ rtl/mgrad_range.sv @@
module mgrad_range
(
    input  mgrad_pkg::win_t win,
    output mgrad_pkg::pix_t range
);

    mgrad_pkg::pix_t hi;
    mgrad_pkg::pix_t lo;

    always_comb
    begin
        hi = win[0];
        lo = win[0];
        for (int i = 1; i < mgrad_pkg::WIN_AREA; i++)
        begin
            if (win[i] > hi)
            begin
                hi = win[i];
            end
            if (win[i] < lo)
            begin
                lo = win[i];
            end
        end
        range = hi - lo;
    end

endmodule

@@ rtl/morphological_gradient_3x3.sv @@
// pipeline: two register stages, stage 1 and the output register, lie between an accepted item and its result
// throughput: one item per cycle while the output is not held, one line store read and one write per cycle
// a held result stalls the input only once both stages hold an item
// reset clears counters, window, valid flags and sets image_width to 1024
// line store contents are not reset
module morphological_gradient_3x3 #(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mgrad_pkg::CFG_W-1:0]  cfg_data,       // image_width

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // pixel
    input  logic [0:0]                   s_axis_tuser,   // frame_start

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata    // gradient, out_row, out_col, zero pad
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW >= 11) ? CW + 1 : 12;
    localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
    localparam logic [CMPW-1:0] WIN_C   = CMPW'(mgrad_pkg::WIN);
    localparam int PAD_W = 32 - mgrad_pkg::PIX_W - 2 * mgrad_pkg::COORD_W;
    localparam int NWIN  = mgrad_pkg::LINES * mgrad_pkg::WIN;

    // configuration
    logic [mgrad_pkg::CFG_W-1:0] width_reg;

    // position counters
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    mgrad_pkg::coord_t row_reg;
    mgrad_pkg::coord_t row_next;

    logic [CW-1:0]     col_cur;
    mgrad_pkg::coord_t row_cur;
    logic [CMPW-1:0]   w_cfg;
    logic [CMPW-1:0]   w_use;
    logic [CMPW-1:0]   col_inc;
    logic              emit;
    logic              in_fire;

    // stage 1
    logic              s1_valid_reg;
    mgrad_pkg::pix_t   s1_pixel_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic              s1_emit_reg;
    mgrad_pkg::coord_t s1_row_reg;
    mgrad_pkg::coord_t s1_col_reg;
    logic              s1_adv;

    // line store, low byte newest line, high byte older line
    logic [2*mgrad_pkg::PIX_W-1:0] store_mem [MAX_WIDTH];
    logic [2*mgrad_pkg::PIX_W-1:0] store_q_reg;
    logic                          fwd_hit_reg;
    logic [2*mgrad_pkg::PIX_W-1:0] fwd_data_reg;
    logic [2*mgrad_pkg::PIX_W-1:0] line_data;
    logic [2*mgrad_pkg::PIX_W-1:0] wr_data;

    // register window, upper half is the newest column
    mgrad_pkg::pix_t [NWIN-1:0] win_reg;
    mgrad_pkg::pix_t [NWIN-1:0] win_next;
    mgrad_pkg::win_t            win_full;
    mgrad_pkg::pix_t            grad;

    // output register
    logic              out_valid_reg;
    mgrad_pkg::pix_t   out_grad_reg;
    mgrad_pkg::coord_t out_row_reg;
    mgrad_pkg::coord_t out_col_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= mgrad_pkg::WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            width_reg <= cfg_data;
        end
    end

    // stage 0: position and window bookkeeping
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign col_cur = s_axis_tuser[0] ? '0 : col_reg;
    assign row_cur = s_axis_tuser[0] ? '0 : row_reg;
    assign w_cfg   = CMPW'(width_reg);
    assign col_inc = CMPW'(col_cur) + CMPW'(1);
    assign emit    = (col_cur >= CW'(mgrad_pkg::LINES))
                  && (row_cur >= mgrad_pkg::COORD_W'(mgrad_pkg::LINES));

    always_comb
    begin
        priority if (w_cfg < WIN_C)
        begin
            w_use = WIN_C;
        end
        else if (w_cfg > MAX_W_C)
        begin
            w_use = MAX_W_C;
        end
        else
        begin
            w_use = w_cfg;
        end

        if (col_inc >= w_use)
        begin
            col_next = '0;
            row_next = (row_cur == mgrad_pkg::ROW_LIMIT) ? row_cur : row_cur + 1'b1;
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign s1_adv        = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
            s1_emit_reg  <= emit;
            fwd_hit_reg  <= s1_adv && (s1_addr_reg == col_cur);
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= s_axis_tdata;
            s1_addr_reg  <= col_cur;
            s1_row_reg   <= row_cur - mgrad_pkg::COORD_W'(mgrad_pkg::LINES);
            s1_col_reg   <= mgrad_pkg::COORD_W'(col_cur)
                          - mgrad_pkg::COORD_W'(mgrad_pkg::LINES);
            fwd_data_reg <= wr_data;
        end
    end

    // stage 1: column assembly, line store aging, range
    assign line_data = fwd_hit_reg ? fwd_data_reg : store_q_reg;
    assign wr_data   = {line_data[mgrad_pkg::PIX_W-1:0], s1_pixel_reg};

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            store_mem[s1_addr_reg] <= wr_data;
        end
        if (in_fire)
        begin
            store_q_reg <= store_mem[col_cur];
        end
    end

    assign win_next = {s1_pixel_reg,
                       line_data[mgrad_pkg::PIX_W-1:0],
                       line_data[2*mgrad_pkg::PIX_W-1:mgrad_pkg::PIX_W],
                       win_reg[NWIN-1:mgrad_pkg::WIN]};
    assign win_full = {win_next, win_reg[mgrad_pkg::WIN-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    mgrad_range u_range
    (
        .win   (win_full),
        .range (grad)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_grad_reg <= grad;
            out_row_reg  <= s1_row_reg;
            out_col_reg  <= s1_col_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_col_reg, out_row_reg, out_grad_reg};

endmodule

@@ test/morphological_gradient_3x3_test.sv @@
module morphological_gradient_3x3_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct packed {
        mgrad_pkg::pix_t   gradient;
        mgrad_pkg::coord_t row;
        mgrad_pkg::coord_t col;
    } gradient_t;

    typedef struct packed {
        mgrad_pkg::pix_t   pixel;
        logic              frame_start;
        logic              typed;
        mgrad_pkg::pix_t   gradient;
        mgrad_pkg::coord_t row;
        mgrad_pkg::coord_t col;
    } stim_row_t;

    typedef enum int {
        FILL_NOISE,
        FILL_FLAT,
        FILL_EXTREME
    } fill_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mgrad_pkg::CFG_W-1:0]   cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;   // pixel
    logic [0:0]                    s_axis_tuser;   // frame_start
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [31:0]                   m_axis_tdata;   // gradient, out_row, out_col, zero pad

    // gradient model state
    mgrad_pkg::pix_t               line_mem [mgrad_pkg::LINES*LINE_DEPTH];
    mgrad_pkg::pix_t               win_mem [mgrad_pkg::LINES*mgrad_pkg::WIN];
    int unsigned                   col_cnt;
    int unsigned                   row_cnt;
    logic [mgrad_pkg::CFG_W-1:0]   width_cfg;

    gradient_t          pending_results [$];
    int                 errors = 0;
    int                 pixels_sent = 0;
    int                 gradients_checked = 0;
    int                 widths_written = 0;
    int                 long_hold_cycles = 0;
    bit                 src_stalls = 1'b1;
    bit                 sink_stalls = 1'b1;

    // window of 3x3: all zero, then 255 enters, then a flat bright patch, then a restart
    stim_row_t directed_rows [25] = '{
        '{8'd0,   1'b1, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b1, 8'd255, 10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b1, 8'd255, 10'd1, 10'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b1, 8'd255, 10'd2, 10'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd255, 1'b0, 1'b1, 8'd0,   10'd3, 10'd0},
        '{8'd200, 1'b1, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd17,  1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd90,  1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd128, 1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd64,  1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd32,  1'b0, 1'b0, 8'd0,   10'd0, 10'd0},
        '{8'd1,   1'b0, 1'b0, 8'd0,   10'd0, 10'd0}
    };

    morphological_gradient_3x3 #(
        .MAX_WIDTH(LINE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin : watchdog
        #20ms;
        $display("morphological_gradient_3x3 verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic int unsigned clamp_width(input logic [mgrad_pkg::CFG_W-1:0] value);
        if (value < mgrad_pkg::WIN)
            return mgrad_pkg::WIN;
        if (value > LINE_DEPTH)
            return LINE_DEPTH;
        return 32'(value);
    endfunction

    task automatic predict_pixel(input mgrad_pkg::pix_t pix, input bit fs, output bit hit,
                                 output gradient_t res);
        mgrad_pkg::pix_t column [mgrad_pkg::WIN];
        mgrad_pkg::pix_t hi;
        mgrad_pkg::pix_t lo;
        int unsigned     c;
        if (fs)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c = (col_cnt >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_cnt;
        for (int i = 0; i < mgrad_pkg::LINES; i++)
            column[i] = line_mem[(mgrad_pkg::LINES - 1 - i)*LINE_DEPTH + c];
        column[mgrad_pkg::WIN-1] = pix;
        for (int k = mgrad_pkg::LINES - 1; k > 0; k--)
            line_mem[k*LINE_DEPTH + c] = line_mem[(k - 1)*LINE_DEPTH + c];
        line_mem[c] = pix;
        hit = 1'b0;
        res = '0;
        if (col_cnt >= mgrad_pkg::LINES && row_cnt >= mgrad_pkg::LINES)
        begin
            hi = column[0];
            lo = column[0];
            foreach (win_mem[i])
            begin
                if (win_mem[i] > hi) hi = win_mem[i];
                if (win_mem[i] < lo) lo = win_mem[i];
            end
            foreach (column[i])
            begin
                if (column[i] > hi) hi = column[i];
                if (column[i] < lo) lo = column[i];
            end
            hit = 1'b1;
            res.gradient = hi - lo;
            res.row = mgrad_pkg::coord_t'(row_cnt - mgrad_pkg::LINES);
            res.col = mgrad_pkg::coord_t'(col_cnt - mgrad_pkg::LINES);
        end
        // slide the window one column left
        for (int i = 0; i + mgrad_pkg::WIN < mgrad_pkg::LINES*mgrad_pkg::WIN; i++)
            win_mem[i] = win_mem[i + mgrad_pkg::WIN];
        for (int i = 0; i < mgrad_pkg::WIN; i++)
            win_mem[(mgrad_pkg::LINES - 1)*mgrad_pkg::WIN + i] = column[i];
        if (col_cnt + 1 >= clamp_width(width_cfg))
        begin
            col_cnt = 0;
            if (row_cnt < mgrad_pkg::ROW_LIMIT)
                row_cnt++;
        end
        else
            col_cnt++;
    endtask

    task automatic send_pixel(input mgrad_pkg::pix_t pix, input bit fs, input bit typed,
                              input gradient_t typed_res);
        bit        hit;
        gradient_t res;
        int        gap;
        if (src_stalls && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= fs;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_pixel(pix, fs, hit, res);
        if (typed)
            pending_results.push_back(typed_res);
        else if (hit)
            pending_results.push_back(res);
        pixels_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [mgrad_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        width_cfg = value;
        widths_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic mgrad_pkg::pix_t make_pixel(input fill_t fill,
                                                   input mgrad_pkg::pix_t base);
        case (fill)
            FILL_NOISE:
                return mgrad_pkg::pix_t'($urandom_range(0, 255));
            FILL_FLAT:
                if ($urandom_range(0, 9) == 0)
                    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    return base;
            default:
                return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // rows of the width in use; cut < 0 keeps the frame whole
    task automatic send_frame(input int rows, input int cut, input fill_t fill,
                              input bit opening, input bit noisy);
        int              total;
        mgrad_pkg::pix_t base;
        bit              fs;
        total = rows * int'(clamp_width(width_cfg));
        if (cut >= 0 && cut < total)
            total = cut;
        base = mgrad_pkg::pix_t'($urandom_range(0, 255));
        for (int n = 0; n < total; n++)
        begin
            fs = (opening && n == 0) || (noisy && $urandom_range(0, 63) == 0);
            send_pixel(make_pixel(fill, base), fs, 1'b0, '0);
        end
    endtask

    initial
    begin : result_sink
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (long_hold_cycles) @(negedge clk);
                long_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        gradient_t         want;
        mgrad_pkg::pix_t   got_gradient;
        mgrad_pkg::coord_t got_row;
        mgrad_pkg::coord_t got_col;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_gradient = m_axis_tdata[7:0];
            got_row = m_axis_tdata[17:8];
            got_col = m_axis_tdata[27:18];
            gradients_checked++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("gradient %0d row %0d col %0d with none expected",
                                          got_gradient, got_row, got_col));
            else
            begin
                want = pending_results.pop_front();
                if (got_gradient !== want.gradient)
                    report_mismatch($sformatf("gradient %0d, expected %0d (row %0d col %0d)",
                                              got_gradient, want.gradient, want.row, want.col));
                if (got_row !== want.row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              got_row, want.row));
                if (got_col !== want.col)
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              got_col, want.col));
                if (m_axis_tdata[31:28] !== 4'b0)
                    report_mismatch($sformatf("pad bits %b not zero", m_axis_tdata[31:28]));
            end
        end
    end

    initial
    begin : stimulus
        int        random_start;
        int        pick;
        gradient_t typed_res;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        width_cfg = mgrad_pkg::WIDTH_RESET;
        col_cnt = 0;
        row_cnt = 0;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win_mem[i]) win_mem[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at a width below the minimum
        write_width(11'd2);
        foreach (directed_rows[i])
        begin
            typed_res.gradient = directed_rows[i].gradient;
            typed_res.row = directed_rows[i].row;
            typed_res.col = directed_rows[i].col;
            send_pixel(directed_rows[i].pixel, directed_rows[i].frame_start,
                       directed_rows[i].typed, typed_res);
        end

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            wait_for_results();
            if (pick == 0)
                write_width(mgrad_pkg::CFG_W'($urandom_range(0, 2)));
            else if (pick == 1)
                write_width(mgrad_pkg::CFG_W'($urandom_range(21, 64)));
            else
                write_width(mgrad_pkg::CFG_W'($urandom_range(3, 20)));
            repeat ($urandom_range(1, 3))
            begin
                src_stalls = $urandom_range(0, 2) != 0;
                sink_stalls = $urandom_range(0, 2) != 0;
                send_frame($urandom_range(3, 6),
                           ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 60)) : -1,
                           fill_t'($urandom_range(0, 2)), 1'b1, 1'b1);
            end
        end

        // receiver holds off while the window rows stream in
        wait_for_results();
        write_width(11'd16);
        src_stalls = 1'b0;
        sink_stalls = 1'b1;
        send_frame(2, -1, FILL_NOISE, 1'b1, 1'b0);
        long_hold_cycles = 60;
        send_frame(2, -1, FILL_EXTREME, 1'b0, 1'b0);

        // no idling from here on
        wait_for_results();
        src_stalls = 1'b0;
        sink_stalls = 1'b0;
        write_width(11'd10);
        send_frame(5, -1, FILL_NOISE, 1'b1, 1'b0);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < 5000 && pending_results.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d gradients never arrived", pending_results.size()));

        $display("%0d pixels sent, %0d gradients checked, %0d width writes",
                 pixels_sent, gradients_checked, widths_written);
        $display("widths 0 to 64 with clamping, restarts inside frames, long output stall");
        if (errors == 0)
            $display("morphological_gradient_3x3 verification clean");
        else
            $display("morphological_gradient_3x3 verification failed");
        $finish;
    end

endmodule
